@@ rtl/core/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the polar converter checks
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, off during reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

// next-cycle implication, also checked through reset
`define ASSERT_NEXT_RST(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ rtl/core/spc_pkg.sv @@
// ---------------------------------------------------------------------------
// spc_pkg
// types and constants of the stick polar converter
// ---------------------------------------------------------------------------
package spc_pkg;

  localparam int GUARD_BITS       = 8;
  localparam int CORDIC_MAX_STEPS = 24;
  localparam int ATAN_W           = 22;
  localparam int Z_W              = 27;
  localparam int ANG_Q16_W        = 25;
  localparam int OUT_W            = 16;
  localparam int GAIN_W           = 30;
  localparam int MAG_FRAC_BITS    = 16;

  localparam logic [GAIN_W-1:0]    INV_GAIN_Q30  = 30'd652032874;
  localparam logic signed [Z_W-1:0] DEG180_Q16   = 27'sd11796480;
  localparam logic signed [Z_W-1:0] DEG360_Q16   = 27'sd23592960;
  localparam logic [ANG_Q16_W:0]   ANG_ROUND     = 26'd256;
  localparam logic [OUT_W-1:0]     ANGLE_WRAP_Q7 = 16'd46080;
  localparam logic [OUT_W-1:0]     MAG_FULL      = 16'd32768;

  // atan(2^-i) in degrees, Q.16
  localparam logic [ATAN_W-1:0] ATAN_DEG_Q16 [CORDIC_MAX_STEPS] = '{
    22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
    22'd58666,   22'd29335,   22'd14668,  22'd7334,   22'd3667,   22'd1833,
    22'd917,     22'd458,     22'd229,    22'd115,    22'd57,     22'd29,
    22'd14,      22'd7,       22'd4,      22'd2,      22'd1,      22'd0
  };

  typedef struct packed {
    logic valid;
    logic zero;
    logic flip;
  } spc_ctl_t;

endpackage

@@ rtl/core/spc_if.sv @@
// ---------------------------------------------------------------------------
// spc_if
// valid/ready channels of the stick polar converter
// ---------------------------------------------------------------------------
interface spc_in_if #(
  parameter int AXIS_BITS = 16
);
  logic                        valid;
  logic                        ready;
  logic signed [AXIS_BITS-1:0] stick_x;
  logic signed [AXIS_BITS-1:0] stick_y;

  modport source (output valid, stick_x, stick_y, input ready);
  modport sink   (input valid, stick_x, stick_y, output ready);
endinterface

interface spc_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] angle_deg;
  logic [15:0] magnitude;

  modport source (output valid, angle_deg, magnitude, input ready);
  modport sink   (input valid, angle_deg, magnitude, output ready);
endinterface

@@ rtl/core/spc_prerot.sv @@
// ---------------------------------------------------------------------------
// spc_prerot
// input stage: mirrors x, scales both axes and folds the left half-plane
// ---------------------------------------------------------------------------
module spc_prerot #(
  parameter int AXIS_BITS = 16,
  parameter int W         = 27
) (
  input  logic                                clk,
  input  logic                                rst_n,
  spc_in_if.sink                              in_if,
  input  logic                                dn_ready,
  output spc_pkg::spc_ctl_t                   ctl,
  output logic signed [W-1:0]                 u,
  output logic signed [W-1:0]                 v,
  output logic signed [spc_pkg::Z_W-1:0]      z
);

  spc_pkg::spc_ctl_t   ctl_r, ctl_nxt;
  logic signed [W-1:0] u_r, u_nxt;
  logic signed [W-1:0] v_r, v_nxt;
  logic signed [W-1:0] xs, ys;
  logic                load;

  assign load        = !ctl_r.valid || dn_ready;
  assign in_if.ready = load;

  always_comb begin
    xs = W'(in_if.stick_x) <<< spc_pkg::GUARD_BITS;
    ys = W'(in_if.stick_y) <<< spc_pkg::GUARD_BITS;
    ctl_nxt.valid = in_if.valid;
    ctl_nxt.zero  = (in_if.stick_x == '0) && (in_if.stick_y == '0);
    // u = -x is negative when x > 0: rotate by 180 degrees
    ctl_nxt.flip  = !in_if.stick_x[AXIS_BITS-1] && (in_if.stick_x != '0);
    if (ctl_nxt.flip) begin
      u_nxt = xs;
      v_nxt = -ys;
    end else begin
      u_nxt = -xs;
      v_nxt = ys;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.valid <= 1'b0;
    end else if (load) begin
      ctl_r <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      u_r <= u_nxt;
      v_r <= v_nxt;
    end
  end

  assign ctl = ctl_r;
  assign u   = u_r;
  assign v   = v_r;
  assign z   = '0;

endmodule

@@ rtl/core/spc_rot_stage.sv @@
// ---------------------------------------------------------------------------
// spc_rot_stage
// one registered CORDIC micro-rotation in vectoring mode
// ---------------------------------------------------------------------------
module spc_rot_stage #(
  parameter int W   = 27,
  parameter int IDX = 0
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  spc_pkg::spc_ctl_t              up_ctl,
  input  logic signed [W-1:0]            up_u,
  input  logic signed [W-1:0]            up_v,
  input  logic signed [spc_pkg::Z_W-1:0] up_z,
  output logic                           up_ready,
  input  logic                           dn_ready,
  output spc_pkg::spc_ctl_t              ctl,
  output logic signed [W-1:0]            u,
  output logic signed [W-1:0]            v,
  output logic signed [spc_pkg::Z_W-1:0] z
);

  localparam logic signed [spc_pkg::Z_W-1:0] ATAN_I =
    spc_pkg::Z_W'(spc_pkg::ATAN_DEG_Q16[IDX]);

  spc_pkg::spc_ctl_t              ctl_r;
  logic signed [W-1:0]            u_r, u_nxt;
  logic signed [W-1:0]            v_r, v_nxt;
  logic signed [spc_pkg::Z_W-1:0] z_r, z_nxt;
  logic signed [W-1:0]            du, dv;
  logic                           v_pos;

  assign up_ready = !ctl_r.valid || dn_ready;

  always_comb begin
    du    = up_v >>> IDX;
    dv    = up_u >>> IDX;
    v_pos = !up_v[W-1] && (up_v != '0);
    if (v_pos) begin
      u_nxt = up_u + du;
      v_nxt = up_v - dv;
      z_nxt = up_z + ATAN_I;
    end else begin
      u_nxt = up_u - du;
      v_nxt = up_v + dv;
      z_nxt = up_z - ATAN_I;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.valid <= 1'b0;
    end else if (up_ready) begin
      ctl_r <= up_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      u_r <= u_nxt;
      v_r <= v_nxt;
      z_r <= z_nxt;
    end
  end

  assign ctl = ctl_r;
  assign u   = u_r;
  assign v   = v_r;
  assign z   = z_r;

endmodule

@@ rtl/core/spc_finish.sv @@
// ---------------------------------------------------------------------------
// spc_finish
// gain correction multiply, angle wrap and rounding, output register
// ---------------------------------------------------------------------------
module spc_finish #(
  parameter int AXIS_BITS = 16,
  parameter int W         = 27
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  spc_pkg::spc_ctl_t              up_ctl,
  input  logic signed [W-1:0]            up_u,
  input  logic signed [spc_pkg::Z_W-1:0] up_z,
  output logic                           up_ready,
  spc_out_if.source                      out_if
);

  localparam int LO_W   = 16;
  localparam int HI_W   = W - 1 - LO_W;
  localparam int PLO_W  = LO_W + spc_pkg::GAIN_W;
  localparam int PHI_W  = HI_W + spc_pkg::GAIN_W;
  localparam int SUM_W  = W + spc_pkg::GAIN_W;
  localparam int SHIFT  = 30 + spc_pkg::GUARD_BITS + AXIS_BITS - spc_pkg::MAG_FRAC_BITS;
  localparam int MAG_W  = SUM_W - SHIFT;
  localparam int AQ_W   = spc_pkg::ANG_Q16_W;

  // stage 1: split multiply, base angle
  spc_pkg::spc_ctl_t              c1_r;
  logic [PLO_W-1:0]               plo_r;
  logic [PHI_W-1:0]               phi_r;
  logic signed [spc_pkg::Z_W-1:0] a1_r;
  // stage 2: product sum, angle wrap
  spc_pkg::spc_ctl_t              c2_r;
  logic [SUM_W-1:0]               sum_r, sum_nxt;
  logic [AQ_W-1:0]                a2_r, a2_nxt;
  // stage 3: output register
  logic                           ov_r;
  logic [spc_pkg::OUT_W-1:0]      ang_r, ang_nxt;
  logic [spc_pkg::OUT_W-1:0]      mag_r, mag_nxt;

  logic                           ld1, ld2, ld3;
  logic [W-2:0]                   um;
  logic [AQ_W:0]                  a_rnd;
  logic [spc_pkg::OUT_W-1:0]      ang_q;
  logic [MAG_W-1:0]               mag_w;
  logic signed [spc_pkg::Z_W-1:0] a_wrap;

  assign ld3      = !ov_r || out_if.ready;
  assign ld2      = !c2_r.valid || ld3;
  assign ld1      = !c1_r.valid || ld2;
  assign up_ready = ld1;
  assign um       = up_u[W-2:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_r.valid <= 1'b0;
    end else if (ld1) begin
      c1_r <= up_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (ld1) begin
      plo_r <= PLO_W'(um[LO_W-1:0]) * PLO_W'(spc_pkg::INV_GAIN_Q30);
      phi_r <= PHI_W'(um[W-2:LO_W]) * PHI_W'(spc_pkg::INV_GAIN_Q30);
      a1_r  <= up_z + (up_ctl.flip ? spc_pkg::DEG180_Q16 : '0);
    end
  end

  always_comb begin
    sum_nxt = (SUM_W'(phi_r) << LO_W) + SUM_W'(plo_r) + (SUM_W'(1) << (SHIFT - 1));
    a_wrap  = a1_r[spc_pkg::Z_W-1] ? (a1_r + spc_pkg::DEG360_Q16) : a1_r;
    a2_nxt  = a_wrap[AQ_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c2_r.valid <= 1'b0;
    end else if (ld2) begin
      c2_r <= c1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ld2) begin
      sum_r <= sum_nxt;
      a2_r  <= a2_nxt;
    end
  end

  always_comb begin
    a_rnd = {1'b0, a2_r} + spc_pkg::ANG_ROUND;
    ang_q = a_rnd[AQ_W-1:9];
    if (ang_q >= spc_pkg::ANGLE_WRAP_Q7) begin
      ang_q = ang_q - spc_pkg::ANGLE_WRAP_Q7;
    end
    mag_w = sum_r[SUM_W-1:SHIFT];
    if (c2_r.zero) begin
      ang_nxt = '0;
      mag_nxt = '0;
    end else begin
      ang_nxt = ang_q;
      if (mag_w > MAG_W'(spc_pkg::MAG_FULL)) begin
        mag_nxt = spc_pkg::MAG_FULL;
      end else begin
        mag_nxt = mag_w[spc_pkg::OUT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (ld3) begin
      ov_r <= c2_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ld3) begin
      ang_r <= ang_nxt;
      mag_r <= mag_nxt;
    end
  end

  assign out_if.valid     = ov_r;
  assign out_if.angle_deg = ang_r;
  assign out_if.magnitude = mag_r;

endmodule

@@ rtl/core/stick_polar_converter_unit.sv @@
// ---------------------------------------------------------------------------
// stick_polar_converter_unit
// stick sample to direction and length, pipelined CORDIC vectoring
// ---------------------------------------------------------------------------
// channel   dir   handshake      payload
// in_if     in    valid/ready    stick_x, stick_y   (signed Q1.15)
// out_if    out   valid/ready    angle_deg (Q9.7), magnitude (Q1.15)
//
// one item per cycle while the output is not stalled; stages in order: input fold
// stage, one stage per micro-rotation, three stages of gain multiply and rounding
// every stage holds its own valid bit; an empty stage loads even while the
// output is stalled, so bubbles close up and nothing is lost or repeated
// synchronous reset clears the valid bits only
// ---------------------------------------------------------------------------
module stick_polar_converter_unit #(
  parameter int CORDIC_STEPS = 16,
  parameter int AXIS_BITS    = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  spc_in_if.sink    in_if,
  spc_out_if.source out_if
);

  localparam int W = AXIS_BITS + spc_pkg::GUARD_BITS + 3;

  spc_pkg::spc_ctl_t              ctl_s [CORDIC_STEPS+1];
  logic signed [W-1:0]            u_s   [CORDIC_STEPS+1];
  logic signed [W-1:0]            v_s   [CORDIC_STEPS+1];
  logic signed [spc_pkg::Z_W-1:0] z_s   [CORDIC_STEPS+1];
  logic                           rdy_s [CORDIC_STEPS+1];

  spc_prerot #(
    .AXIS_BITS (AXIS_BITS),
    .W         (W)
  ) u_prerot (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_if),
    .dn_ready (rdy_s[0]),
    .ctl      (ctl_s[0]),
    .u        (u_s[0]),
    .v        (v_s[0]),
    .z        (z_s[0])
  );

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
    spc_rot_stage #(
      .W   (W),
      .IDX (i)
    ) u_rot (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_ctl   (ctl_s[i]),
      .up_u     (u_s[i]),
      .up_v     (v_s[i]),
      .up_z     (z_s[i]),
      .up_ready (rdy_s[i]),
      .dn_ready (rdy_s[i+1]),
      .ctl      (ctl_s[i+1]),
      .u        (u_s[i+1]),
      .v        (v_s[i+1]),
      .z        (z_s[i+1])
    );
  end

  spc_finish #(
    .AXIS_BITS (AXIS_BITS),
    .W         (W)
  ) u_finish (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_ctl   (ctl_s[CORDIC_STEPS]),
    .up_u     (u_s[CORDIC_STEPS]),
    .up_z     (z_s[CORDIC_STEPS]),
    .up_ready (rdy_s[CORDIC_STEPS]),
    .out_if   (out_if)
  );

endmodule

@@ rtl/core/spc_checker.sv @@
// ---------------------------------------------------------------------------
// spc_checker
// port-level checks of the stick polar converter, bound to the top level
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module spc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] angle_deg,
  input logic [15:0] magnitude
);

  // a stalled result holds its value
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(angle_deg) && $stable(magnitude))

  // a free output lets the whole pipeline move
  `ASSERT_IMPL(a_flow, clk, rst_n, out_ready, in_ready)

  // results stay inside their ranges
  `ASSERT_IMPL(a_range, clk, rst_n, out_valid, (angle_deg < 16'd46080) && (magnitude <= 16'd32768))

  // reset leaves no result behind
  `ASSERT_NEXT_RST(a_rst_empty, clk, !rst_n, !out_valid)

endmodule

bind stick_polar_converter_unit spc_checker u_spc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_if.ready),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .angle_deg (out_if.angle_deg),
  .magnitude (out_if.magnitude)
);

@@ sim/stick_polar_converter_unit_test.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// stick_polar_converter_unit_test
// self-checking bench for the stick polar converter: a queue of stick
// samples feeds a valid/ready driver with random gaps, and a monitor
// predicts direction and length of each accepted item in fixed point and
// compares them with the results, which leave under random back-pressure
// ---------------------------------------------------------------------------
module stick_polar_converter_unit_test;

  localparam int CORDIC_STEPS = 16;
  localparam int AXIS_BITS    = 16;
  localparam int LATENCY      = CORDIC_STEPS + 4;

  typedef struct {
    logic signed [AXIS_BITS-1:0] stick_x;
    logic signed [AXIS_BITS-1:0] stick_y;
  } stick_t;

  typedef struct {
    logic [spc_pkg::OUT_W-1:0] angle_deg;
    logic [spc_pkg::OUT_W-1:0] magnitude;
  } polar_t;

  logic clk;
  logic rst_n;

  spc_in_if #(.AXIS_BITS(AXIS_BITS)) in_bus();
  spc_out_if                         out_bus();

  stick_polar_converter_unit #(
    .CORDIC_STEPS(CORDIC_STEPS),
    .AXIS_BITS   (AXIS_BITS)
  ) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_bus),
    .out_if(out_bus)
  );

  stick_t stick_queue[$];
  polar_t polar_expected[$];
  stick_t cur_stick;
  polar_t got_polar;
  polar_t want_polar;
  int     error_count = 0;
  bit     in_busy     = 0;
  bit     in_taken    = 0;
  bit     send_calm   = 0;
  bit     recv_calm   = 0;
  int     send_gap    = 0;
  int     stall_cnt   = 0;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic polar_t compute_polar(input logic signed [AXIS_BITS-1:0] sx,
                                           input logic signed [AXIS_BITS-1:0] sy);
    longint u, v, du, dv, base, z, a;
    longint unsigned ang, mag;
    int shift;
    polar_t r;
    u = -(longint'(sx)) * (longint'(1) <<< spc_pkg::GUARD_BITS);
    v = longint'(sy) * (longint'(1) <<< spc_pkg::GUARD_BITS);
    base = 0;
    z = 0;
    r.angle_deg = '0;
    r.magnitude = '0;
    if (u == 0 && v == 0) return r;
    // fold into the right half plane
    if (u < 0) begin
      u = -u;
      v = -v;
      base = longint'(spc_pkg::DEG180_Q16);
    end
    for (int i = 0; i < CORDIC_STEPS && i < spc_pkg::CORDIC_MAX_STEPS; i++) begin
      du = v >>> i;
      dv = u >>> i;
      if (v > 0) begin
        u = u + du;
        v = v - dv;
        z = z + longint'(spc_pkg::ATAN_DEG_Q16[i]);
      end else begin
        u = u - du;
        v = v + dv;
        z = z - longint'(spc_pkg::ATAN_DEG_Q16[i]);
      end
    end
    a = base + z;
    if (a < 0) a = a + longint'(spc_pkg::DEG360_Q16);
    ang = ($unsigned(a) + 64'd256) >> 9;
    if (ang >= 64'(spc_pkg::ANGLE_WRAP_Q7)) ang = ang - 64'(spc_pkg::ANGLE_WRAP_Q7);
    shift = 30 + spc_pkg::GUARD_BITS + AXIS_BITS - 16;
    mag = ($unsigned(u) * 64'(spc_pkg::INV_GAIN_Q30) + (64'd1 << (shift - 1))) >> shift;
    if (mag > 64'(spc_pkg::MAG_FULL)) mag = 64'(spc_pkg::MAG_FULL);
    r.angle_deg = ang[spc_pkg::OUT_W-1:0];
    r.magnitude = mag[spc_pkg::OUT_W-1:0];
    return r;
  endfunction

  function automatic logic signed [AXIS_BITS-1:0] near_full();
    if ($urandom_range(0, 1) == 0) return AXIS_BITS'($urandom_range(32000, 32767));
    return -AXIS_BITS'($urandom_range(32000, 32768));
  endfunction

  task automatic add_stick(input int x, input int y);
    stick_t s;
    s.stick_x = x[AXIS_BITS-1:0];
    s.stick_y = y[AXIS_BITS-1:0];
    stick_queue.push_back(s);
  endtask

  task automatic add_random_stick();
    int    kind;
    int    x, y;
    kind = $urandom_range(0, 99);
    x = $urandom;
    y = $urandom;
    if (kind < 40) begin
    end else if (kind < 60) begin
      x = $urandom_range(0, 128) - 64;
      y = $urandom_range(0, 128) - 64;
    end else if (kind < 80) begin
      if ($urandom_range(0, 1) == 0) x = near_full();
      else y = near_full();
    end else if (kind < 90) begin
      if ($urandom_range(0, 1) == 0) x = 0;
      else y = 0;
    end else begin
      y = ($urandom_range(0, 1) == 0) ? x : -x;
      if ($urandom_range(0, 3) == 0) x = -32768;
    end
    add_stick(x, y);
  endtask

  // input driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else begin
      if (in_taken) begin
        in_busy  = 0;
        in_taken = 0;
      end
      if (!in_busy) begin
        if (send_gap > 0) begin
          send_gap--;
          in_bus.valid <= 1'b0;
        end else if (stick_queue.size() > 0) begin
          cur_stick = stick_queue.pop_front();
          in_bus.stick_x <= cur_stick.stick_x;
          in_bus.stick_y <= cur_stick.stick_y;
          in_bus.valid   <= 1'b1;
          in_busy = 1;
          if ($urandom_range(0, 99) == 0) send_calm = ~send_calm;
          send_gap = send_calm ? 0 : pick_gap();
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // result back-pressure
  always @(negedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else if (stall_cnt > 0) begin
      stall_cnt--;
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= 1'b1;
      if ($urandom_range(0, 199) == 0) recv_calm = ~recv_calm;
      if (!recv_calm && $urandom_range(0, 3) == 0) stall_cnt = pick_gap();
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_bus.valid && in_bus.ready) begin
        polar_expected.push_back(compute_polar(in_bus.stick_x, in_bus.stick_y));
        in_taken = 1;
      end
      if (out_bus.valid && out_bus.ready) begin
        got_polar.angle_deg = out_bus.angle_deg;
        got_polar.magnitude = out_bus.magnitude;
        if (polar_expected.size() == 0) begin
          $error("unexpected item angle_deg %0d magnitude %0d",
                 got_polar.angle_deg, got_polar.magnitude);
          error_count++;
        end else begin
          want_polar = polar_expected.pop_front();
          if (got_polar.angle_deg !== want_polar.angle_deg) begin
            $error("angle_deg expected %0d actual %0d",
                   want_polar.angle_deg, got_polar.angle_deg);
            error_count++;
          end
          if (got_polar.magnitude !== want_polar.magnitude) begin
            $error("magnitude expected %0d actual %0d",
                   want_polar.magnitude, got_polar.magnitude);
            error_count++;
          end
        end
      end
    end
  end

  initial begin
    rst_n          = 1'b0;
    in_bus.valid   = 1'b0;
    in_bus.stick_x = '0;
    in_bus.stick_y = '0;
    out_bus.ready  = 1'b0;

    // extremes, axes, diagonals and the wrap at 360
    add_stick(0, 0);
    add_stick(-32768, 0);
    add_stick(32767, 0);
    add_stick(0, 32767);
    add_stick(0, -32768);
    add_stick(-32768, -32768);
    add_stick(32767, 32767);
    add_stick(-32768, 32767);
    add_stick(32767, -32768);
    add_stick(1, 0);
    add_stick(-1, 0);
    add_stick(0, 1);
    add_stick(0, -1);
    add_stick(1, 1);
    add_stick(-1, -1);
    add_stick(-32767, -1);
    add_stick(-32767, 1);
    add_stick(32767, 1);
    add_stick(32767, -1);
    add_stick(-23170, 23170);
    add_stick(23170, -23170);
    add_stick(-32768, -1);
    for (int n = 0; n < 800; n++) add_random_stick();

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    while (stick_queue.size() != 0 || in_busy || polar_expected.size() != 0)
      @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);

    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout");
    $display("== FAIL ==");
    $finish;
  end

endmodule
